/* src/c8_pkg.sv */
// Package: constants, opcode helpers and control state type for the CHIP-8 core.
`default_nettype none
package c8_pkg;
  localparam int MemDepthDef   = 4096;
  localparam int StackDepthDef = 16;
  localparam int DispW         = 64;
  localparam int DispH         = 32;
  localparam logic [11:0] StartReset = 12'h200;

  localparam logic [1:0] FUNC_EXEC  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR,
    S_FETCH0,
    S_FETCH1,
    S_FETCH2,
    S_EXEC,
    S_RET,
    S_BCD,
    S_STORE,
    S_LOAD_RD,
    S_LOAD_WR,
    S_DRAW_RD,
    S_DRAW_FB,
    S_DRAW_WR,
    S_ROW_RD,
    S_ROW_WAIT,
    S_DONE
  } state_t;

  // x * 5 for the font address
  function automatic logic [15:0] times5(input logic [7:0] v);
    times5 = {6'd0, v, 2'b00} + {8'd0, v};
  endfunction
endpackage
`default_nettype wire

/* src/c8_if.sv */
// Valid/ready channel interface carrying one payload.
`default_nettype none
interface c8_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/c8_ram.sv */
// Generic single-port synchronous RAM, registered read.
`default_nettype none
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* src/chip8_instruction_core_unit.sv */
// CHIP-8 core top level: memories, register file and instruction sequencer.
// channel | dir | payload
// in      | in  | func, address, write_data, display_row, key_state, random_byte
// out     | out | program_counter_out, row_pixels, display_changed, waiting_for_key,
//         |     | sound_level, delay_level
// cfg     | in  | start_address (cfg_we, cfg_data)
// One item at a time. A memory write, a row read and each instruction end in the
// result state; 00E0 adds a 32-row sweep, FX33 writes three BCD digits, FX55 and
// FX65 step through V0 to VX, and DXYN through each sprite row. All memory traffic goes
// through the one memory port.
// After reset a pass over all 32 rows clears the frame buffer before the first beat.
// A stalled output holds the result and blocks the next input beat.
`default_nettype none
module chip8_instruction_core_unit #(
  parameter int MEM_DEPTH   = c8_pkg::MemDepthDef,
  parameter int STACK_DEPTH = c8_pkg::StackDepthDef
) (
  input wire logic clk,
  input wire logic rst,
  c8_if.sink       in_ch,
  c8_if.source     out_ch,
  input wire logic        cfg_we,
  input wire logic [11:0] cfg_data
);
  import c8_pkg::*;
  localparam int AW = $clog2(MEM_DEPTH);
  localparam int SW = $clog2(STACK_DEPTH);

  state_t state, state_next;

  logic [11:0] start_address;
  logic [11:0] pc;
  logic [15:0] ireg;
  logic [7:0]  v [16];
  logic [SW-1:0] sp;
  logic [7:0]  dt, st;
  logic [15:0] op;
  logic [15:0] keys;
  logic [7:0]  rnd;
  logic [4:0]  row_sel;
  logic [3:0]  cnt;
  logic [7:0]  sprite;
  logic        hit;
  logic [4:0]  fb_cnt;
  logic        changed, waiting;
  logic [63:0] row_out;

  // main memory
  logic          m_we;
  logic [AW-1:0] m_addr;
  logic [7:0]    m_wd, m_rd;
  c8_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd)
  );

  // frame buffer
  logic        f_we;
  logic [4:0]  f_addr;
  logic [63:0] f_wd, f_rd;
  c8_ram #(.WIDTH(64), .DEPTH(DispH)) u_fb (
    .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wd), .rdata(f_rd)
  );

  // call stack
  logic          s_we;
  logic [SW-1:0] s_addr;
  logic [11:0]   s_rd;
  c8_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(pc), .rdata(s_rd)
  );

  logic [SW-1:0] sp_inc, sp_dec;
  assign sp_inc = (sp == SW'(STACK_DEPTH - 1)) ? '0 : sp + SW'(1);
  assign sp_dec = (sp == '0) ? SW'(STACK_DEPTH - 1) : sp - SW'(1);

  logic [3:0] ox, oy, on;
  logic [7:0] vx, vy, nn;
  assign ox = op[11:8];
  assign oy = op[7:4];
  assign on = op[3:0];
  assign nn = op[7:0];
  assign vx = v[ox];
  assign vy = v[oy];

  logic [15:0] ia;
  assign ia = ireg + {12'd0, cnt};

  logic [4:0]  yrow;
  logic [63:0] smask;
  logic [5:0]  xs;
  logic        hit_now;
  assign yrow = vy[4:0] + {1'b0, cnt};
  assign xs   = vx[5:0];
  // sprite byte placed at column x with wrap
  always_comb begin
    smask = {sprite, 56'd0};
    smask = (smask >> xs) | (smask << (7'd64 - {1'b0, xs}));
  end
  assign hit_now = hit | ((f_rd & smask) != 64'd0);

  // BCD digits
  logic [7:0] bcd_h, bcd_t, bcd_o;
  always_comb begin
    bcd_h = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
    bcd_o = vx - 8'(bcd_h * 8'd100);
    bcd_t = 8'd0;
    for (int k = 1; k < 10; k++) begin
      if (bcd_o >= 8'(k * 10)) bcd_t = 8'(k);
    end
    bcd_o = bcd_o - 8'(bcd_t * 8'd10);
  end

  logic [3:0] low_key;
  always_comb begin
    low_key = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (keys[k]) low_key = 4'(k);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      // the sweep after reset returns to idle, the one for 00E0 reports a result
      S_CLR:  if (fb_cnt == 5'd31) state_next = changed ? S_DONE : S_IDLE;
      S_IDLE:
        if (in_ch.valid) begin
          case (in_ch.data.func)
            FUNC_EXEC:  state_next = S_FETCH0;
            FUNC_READ:  state_next = S_ROW_RD;
            default:    state_next = S_DONE;
          endcase
        end
      S_ROW_RD:   state_next = S_ROW_WAIT;
      S_ROW_WAIT: state_next = S_DONE;
      S_FETCH0:   state_next = S_FETCH1;
      S_FETCH1:   state_next = S_FETCH2;
      S_FETCH2:   state_next = S_EXEC;
      S_EXEC: begin
        state_next = S_DONE;
        case (op[15:12])
          4'h0: if (op == 16'h00E0) state_next = S_CLR;
                else if (op == 16'h00EE) state_next = S_RET;
          4'hD: if (on != 4'd0) state_next = S_DRAW_RD;
          4'hF: begin
            if (nn == 8'h33) state_next = S_BCD;
            else if (nn == 8'h55) state_next = S_STORE;
            else if (nn == 8'h65) state_next = S_LOAD_RD;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_RET:     state_next = S_DONE;
      S_BCD:     if (cnt == 4'd2) state_next = S_DONE;
      S_STORE:   if (cnt == ox) state_next = S_DONE;
      S_LOAD_RD: state_next = S_LOAD_WR;
      S_LOAD_WR: state_next = (cnt == ox) ? S_DONE : S_LOAD_RD;
      S_DRAW_RD: state_next = S_DRAW_FB;
      S_DRAW_FB: state_next = S_DRAW_WR;
      S_DRAW_WR: state_next = (cnt == on - 4'd1) ? S_DONE : S_DRAW_RD;
      S_DONE:    if (out_ch.ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // memory, frame buffer and stack ports
  always_comb begin
    m_we   = 1'b0;
    m_addr = ia[AW-1:0];
    m_wd   = v[cnt];
    f_we   = 1'b0;
    f_addr = yrow;
    f_wd   = f_rd ^ smask;
    s_we   = 1'b0;
    s_addr = sp;
    case (state)
      S_IDLE: begin
        m_addr = AW'(in_ch.data.address);
        m_wd   = in_ch.data.write_data;
        m_we   = in_ch.valid && (in_ch.data.func == FUNC_WRITE);
      end
      S_FETCH0:  m_addr = AW'(pc);
      S_FETCH1:  m_addr = AW'(pc + 12'd1);
      S_EXEC: begin
        s_we = (op[15:12] == 4'h2);
        if (op == 16'h00EE) s_addr = sp_dec;
      end
      S_BCD: begin
        m_we = 1'b1;
        m_wd = (cnt == 4'd0) ? bcd_h : (cnt == 4'd1) ? bcd_t : bcd_o;
      end
      S_STORE:   m_we = 1'b1;
      S_CLR: begin
        f_we   = 1'b1;
        f_addr = fb_cnt;
        f_wd   = 64'd0;
      end
      S_ROW_RD:  f_addr = row_sel;
      S_DRAW_WR: f_we = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    out_ch.valid = (state == S_DONE);
    in_ch.ready  = (state == S_IDLE);
    out_ch.data.program_counter_out = pc;
    out_ch.data.row_pixels          = row_out;
    out_ch.data.display_changed     = changed;
    out_ch.data.waiting_for_key     = waiting;
    out_ch.data.sound_level         = st;
    out_ch.data.delay_level         = dt;
  end

  logic [11:0] pc2;
  logic [8:0]  sum;
  logic [16:0] isum;
  assign pc2  = pc + 12'd2;
  assign sum  = {1'b0, vx} + {1'b0, vy};
  assign isum = {1'b0, ireg} + {9'd0, vx};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      pc            <= start_address;
      ireg          <= 16'd0;
      sp            <= '0;
      dt            <= 8'd0;
      st            <= 8'd0;
      fb_cnt        <= 5'd0;
      changed       <= 1'b0;
      for (int k = 0; k < 16; k++) v[k] <= 8'd0;
    end else begin
      state <= state_next;
      case (state)
        S_CLR: fb_cnt <= fb_cnt + 5'd1;
        S_IDLE: if (in_ch.valid) begin
          keys    <= in_ch.data.key_state;
          rnd     <= in_ch.data.random_byte;
          row_sel <= in_ch.data.display_row;
          row_out <= 64'd0;
          changed <= 1'b0;
          waiting <= 1'b0;
          cnt     <= 4'd0;
          fb_cnt  <= 5'd0;
        end
        S_ROW_WAIT: row_out <= f_rd;
        S_FETCH1: op[15:8] <= m_rd;
        S_FETCH2: begin
          op[7:0] <= m_rd;
          pc      <= pc2;
        end
        S_EXEC: begin
          case (op[15:12])
            4'h0: begin
              if (op == 16'h00E0) changed <= 1'b1;
              else if (op == 16'h00EE) sp <= sp_dec;
            end
            4'h1: pc <= op[11:0];
            4'h2: begin
              sp <= sp_inc;
              pc <= op[11:0];
            end
            4'h3: if (vx == nn) pc <= pc2;
            4'h4: if (vx != nn) pc <= pc2;
            4'h5: if (vx == vy) pc <= pc2;
            4'h6: v[ox] <= nn;
            4'h7: v[ox] <= vx + nn;
            4'h8: begin
              case (on)
                4'h0: v[ox] <= vy;
                4'h1: v[ox] <= vx | vy;
                4'h2: v[ox] <= vx & vy;
                4'h3: v[ox] <= vx ^ vy;
                4'h4: begin v[ox] <= sum[7:0]; v[15] <= {7'd0, sum[8]}; end
                4'h5: begin v[ox] <= vx - vy; v[15] <= {7'd0, vx >= vy}; end
                4'h6: begin v[ox] <= vx >> 1; v[15] <= {7'd0, vx[0]}; end
                4'h7: begin v[ox] <= vy - vx; v[15] <= {7'd0, vy >= vx}; end
                4'hE: begin v[ox] <= vx << 1; v[15] <= {7'd0, vx[7]}; end
                default: ;
              endcase
            end
            4'h9: if (vx != vy) pc <= pc2;
            4'hA: ireg <= {4'd0, op[11:0]};
            4'hB: pc <= op[11:0] + {4'd0, v[0]};
            4'hC: v[ox] <= ((rnd == 8'hFF) ? 8'd0 : rnd) & nn;
            4'hD: begin
              // VF is written once the last row is done so VX and VY stay put; with N = 0 it is cleared here
              if (on == 4'd0) v[15] <= 8'd0;
              hit     <= 1'b0;
              changed <= 1'b1;
            end
            4'hE: begin
              if (nn == 8'h9E && keys[vx[3:0]]) pc <= pc2;
              else if (nn == 8'hA1 && !keys[vx[3:0]]) pc <= pc2;
            end
            default: begin
              case (nn)
                8'h07: v[ox] <= dt;
                8'h0A: begin
                  if (keys != 16'd0) v[ox] <= {4'd0, low_key};
                  else begin
                    pc      <= pc - 12'd2;
                    waiting <= 1'b1;
                  end
                end
                8'h15: dt <= vx;
                8'h18: st <= vx;
                8'h1E: begin
                  ireg  <= isum[15:0];
                  v[15] <= {7'd0, isum[16:12] != 5'd0};
                end
                8'h29: ireg <= times5(vx);
                default: ;
              endcase
            end
          endcase
        end
        S_RET: pc <= s_rd;
        S_BCD, S_STORE: cnt <= cnt + 4'd1;
        S_LOAD_WR: begin
          v[cnt] <= m_rd;
          cnt    <= cnt + 4'd1;
        end
        S_DRAW_FB: sprite <= m_rd;
        S_DRAW_WR: begin
          hit <= hit_now;
          if (cnt == on - 4'd1) v[15] <= {7'd0, hit_now};
          cnt <= cnt + 4'd1;
        end
        default: ;
      endcase
    end
  end

  // start address register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= StartReset;
    end else if (cfg_we) begin
      start_address <= cfg_data;
    end
  end
endmodule
`default_nettype wire

/* src/c8_checker.sv */
// Port-level checks on the CHIP-8 core, bound to the top level.
`default_nettype none
module c8_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [63:0] row_pixels,
  input wire logic [11:0] pc
);
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_accept_clears_ready: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(pc) && $stable(row_pixels))
    else $error("result dropped under stall");
  a_no_result_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("result while idle");
endmodule

bind chip8_instruction_core_unit c8_checker u_c8_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .row_pixels(out_ch.data.row_pixels), .pc(out_ch.data.program_counter_out)
);
`default_nettype wire
